### rtl/pic_pkg.sv
// Shared types, constants and the fixed source table of the priority interrupt controller.
package pic_pkg;

    localparam int NUM_SOURCES = 28;
    localparam int SRC_W       = 5;
    localparam int LEVEL_W     = 4;
    localparam int CODE_W      = 11;
    localparam int WORD_W      = 16;
    localparam int MODE_W      = 3;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET_PEND = 3'd0,
        MODE_CLR_PEND = 3'd1,
        MODE_ENABLE   = 3'd2,
        MODE_DISABLE  = 3'd3,
        MODE_EVAL     = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WORD_A = 2'd0,
        CFG_WORD_B = 2'd1,
        CFG_WORD_C = 2'd2
    } t_cfg_idx;

    // Where a source takes its level from.
    typedef enum logic [1:0] {
        LVL_WORD_A = 2'd0,
        LVL_WORD_B = 2'd1,
        LVL_WORD_C = 2'd2,
        LVL_FIXED  = 2'd3
    } t_lvl_sel;

    typedef struct packed {
        t_lvl_sel            sel;
        logic [LEVEL_W-1:0]  arg;   // nibble number, or the fixed level
        logic [CODE_W-1:0]   code;
    } t_src_desc;

    typedef struct packed {
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic [WORD_W-1:0] word_c;
    } t_prio_words;

    // Snapshot handed from the state stage to the arbiter.
    typedef struct packed {
        logic                   valid;
        logic [NUM_SOURCES-1:0] active;
        logic [LEVEL_W-1:0]     imask;
        logic                   block;
    } t_eval_req;

    localparam t_src_desc SRC_TAB [NUM_SOURCES] = '{
        '{LVL_FIXED,  4'd6, 11'h320}, '{LVL_FIXED,  4'd4, 11'h360},
        '{LVL_FIXED,  4'd2, 11'h3A0},
        '{LVL_WORD_C, 4'd0, 11'h600},
        '{LVL_WORD_C, 4'd3, 11'h620},
        '{LVL_WORD_C, 4'd2, 11'h640}, '{LVL_WORD_C, 4'd2, 11'h660},
        '{LVL_WORD_C, 4'd2, 11'h680}, '{LVL_WORD_C, 4'd2, 11'h6A0},
        '{LVL_WORD_C, 4'd2, 11'h6C0},
        '{LVL_WORD_A, 4'd3, 11'h400}, '{LVL_WORD_A, 4'd2, 11'h420},
        '{LVL_WORD_A, 4'd1, 11'h440}, '{LVL_WORD_A, 4'd1, 11'h460},
        '{LVL_WORD_A, 4'd0, 11'h480}, '{LVL_WORD_A, 4'd0, 11'h4A0},
        '{LVL_WORD_A, 4'd0, 11'h4C0},
        '{LVL_WORD_B, 4'd1, 11'h4E0}, '{LVL_WORD_B, 4'd1, 11'h500},
        '{LVL_WORD_B, 4'd1, 11'h520}, '{LVL_WORD_B, 4'd1, 11'h540},
        '{LVL_WORD_C, 4'd1, 11'h700}, '{LVL_WORD_C, 4'd1, 11'h720},
        '{LVL_WORD_C, 4'd1, 11'h740}, '{LVL_WORD_C, 4'd1, 11'h760},
        '{LVL_WORD_B, 4'd3, 11'h560},
        '{LVL_WORD_B, 4'd2, 11'h580}, '{LVL_WORD_B, 4'd2, 11'h5A0}
    };

endpackage

### rtl/pic_state.sv
// Pending and enable bit registers and the input register that feeds the arbiter.
module pic_state
    import pic_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [SRC_W-1:0]   i_source,
    input  logic [LEVEL_W-1:0] i_sr_imask,
    input  logic               i_sr_block,
    output t_eval_req          o_req
);

    logic [NUM_SOURCES-1:0] r_pending, n_pending;
    logic [NUM_SOURCES-1:0] r_enable,  n_enable;
    logic                   r_valid;
    logic [NUM_SOURCES-1:0] r_active;
    logic [LEVEL_W-1:0]     r_imask;
    logic                   r_block;
    logic [NUM_SOURCES-1:0] w_bit;
    logic                   w_in_range;

    assign w_in_range = (i_source < SRC_W'(NUM_SOURCES));
    assign w_bit      = NUM_SOURCES'(1) << i_source;

    // The bit update lands before evaluation, so the snapshot uses the new bits.
    always_comb begin
        n_pending = r_pending;
        n_enable  = r_enable;
        if (i_start && w_in_range) begin
            case (i_mode)
                MODE_SET_PEND: n_pending = r_pending | w_bit;
                MODE_CLR_PEND: n_pending = r_pending & ~w_bit;
                MODE_ENABLE:   n_enable  = r_enable | w_bit;
                MODE_DISABLE:  n_enable  = r_enable & ~w_bit;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_enable  <= '1;
            r_valid   <= 1'b0;
        end else begin
            r_pending <= n_pending;
            r_enable  <= n_enable;
            r_valid   <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_active <= n_pending & n_enable;
            r_imask  <= i_sr_imask;
            r_block  <= i_sr_block;
        end
    end

    assign o_req = '{valid: r_valid, active: r_active, imask: r_imask, block: r_block};

endmodule

### rtl/pic_arbiter.sv
// Level lookup, priority selection and the result register.
module pic_arbiter
    import pic_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_eval_req          i_req,
    input  t_prio_words        i_words,
    output logic               o_valid,
    output logic               o_take,
    output logic [CODE_W-1:0]  o_event_code,
    output logic [SRC_W-1:0]   o_winner,
    output logic [LEVEL_W-1:0] o_win_level
);

    logic [LEVEL_W-1:0]     w_level [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] w_elig;
    logic [NUM_SOURCES-1:0] w_top;
    logic [LEVEL_W-1:0]     w_win_level;
    logic [SRC_W-1:0]       w_winner;
    logic [CODE_W-1:0]      w_code;
    logic                   w_take;

    logic                   r_valid;
    logic                   r_take;
    logic [CODE_W-1:0]      r_code;
    logic [SRC_W-1:0]       r_winner;
    logic [LEVEL_W-1:0]     r_level;

    // Each source's level and whether it can be taken at all.
    always_comb begin
        for (int i = 0; i < NUM_SOURCES; i++) begin
            case (SRC_TAB[i].sel)
                LVL_WORD_A: w_level[i] = i_words.word_a[SRC_TAB[i].arg[1:0]*LEVEL_W +: LEVEL_W];
                LVL_WORD_B: w_level[i] = i_words.word_b[SRC_TAB[i].arg[1:0]*LEVEL_W +: LEVEL_W];
                LVL_WORD_C: w_level[i] = i_words.word_c[SRC_TAB[i].arg[1:0]*LEVEL_W +: LEVEL_W];
                default:    w_level[i] = SRC_TAB[i].arg;
            endcase
            w_elig[i] = i_req.active[i] && !i_req.block && (w_level[i] > i_req.imask);
        end
    end

    // Highest level present among eligible sources.
    always_comb begin
        w_win_level = '0;
        for (int l = 1; l < (1 << LEVEL_W); l++) begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
                if (w_elig[i] && (w_level[i] == LEVEL_W'(l))) begin
                    w_win_level = LEVEL_W'(l);
                end
            end
        end
    end

    // Among sources at that level the highest index wins.
    always_comb begin
        w_winner = '0;
        w_code   = '0;
        for (int i = 0; i < NUM_SOURCES; i++) begin
            w_top[i] = w_elig[i] && (w_level[i] == w_win_level);
        end
        for (int i = 0; i < NUM_SOURCES; i++) begin
            if (w_top[i]) begin
                w_winner = SRC_W'(i);
                w_code   = SRC_TAB[i].code;
            end
        end
        w_take = |w_elig;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_take   <= w_take;
            r_code   <= w_code;
            r_winner <= w_winner;
            r_level  <= w_win_level;
        end
    end

    assign o_valid      = r_valid;
    assign o_take       = r_take;
    assign o_event_code = r_code;
    assign o_winner     = r_winner;
    assign o_win_level  = r_level;

endmodule

### rtl/priority_interrupt_controller.sv
// Top level of the priority interrupt controller with its priority registers.
//
// Usage: a command is issued by raising i_start with i_mode, i_source, i_sr_imask
// and i_sr_block; it is accepted at any rising edge where i_start is high and
// o_busy is low. The controller never stalls, so o_busy is always low and one
// transaction can be accepted in every cycle.
// Each command first sets or clears one source's pending or enable bit (an
// out-of-range source or an unused mode only evaluates), then arbitrates over
// the 28 sources with the supplied mask and block bit.
// The command is captured in the state stage with the updated bit snapshot, and
// the arbiter result is registered in the cycle after. o_valid marks the single
// cycle in which the result ports hold the result; the receiver cannot hold
// results off, so none is ever delayed. Throughput is one command per cycle,
// since the priority compare is combinational. When no source wins, o_take is
// low and the other result fields are zero. The three priority words are written
// through the configuration channel, which is always ready; index 3 is ignored.
// The user must ensure writes are made while idle; the block does not enforce it.
// Reset (synchronous, active low) clears all pending bits, sets all enable bits,
// clears the priority words and drops any command still in flight.
module priority_interrupt_controller
    import pic_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [SRC_W-1:0]     i_source,
    input  logic [LEVEL_W-1:0]   i_sr_imask,
    input  logic                 i_sr_block,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    output logic                 o_valid,
    output logic                 o_take,
    output logic [CODE_W-1:0]    o_event_code,
    output logic [SRC_W-1:0]     o_winner,
    output logic [LEVEL_W-1:0]   o_win_level
);

    t_prio_words r_words;
    t_eval_req   w_req;
    logic        w_accept;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_start && !o_busy;

    // Priority registers; a write to the unused index changes nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WORD_A: r_words.word_a <= i_cfg_data;
                CFG_WORD_B: r_words.word_b <= i_cfg_data;
                CFG_WORD_C: r_words.word_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pic_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_mode     (i_mode),
        .i_source   (i_source),
        .i_sr_imask (i_sr_imask),
        .i_sr_block (i_sr_block),
        .o_req      (w_req)
    );

    pic_arbiter u_arbiter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_req),
        .i_words      (r_words),
        .o_valid      (o_valid),
        .o_take       (o_take),
        .o_event_code (o_event_code),
        .o_winner     (o_winner),
        .o_win_level  (o_win_level)
    );

endmodule

### dv/tb_priority_interrupt_controller.sv
// Self-checking testbench for the priority interrupt controller: directed and random commands.
module tb_priority_interrupt_controller;
    import pic_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The slowest correct run stays far below this count.
    // That run has about 1300 commands, idle bursts, and the drains between phases.
    localparam int CYCLE_LIMIT  = 200000;
    // A result passes the state and arbiter registers; a drain adds these idle ticks after the last one.
    localparam int SETTLE_TICKS = 4;
    localparam int PHASE_ITEMS  = 215;

    // One arbitration outcome, as the result ports present it.
    typedef struct {
        bit               take;
        bit [CODE_W-1:0]  code;
        bit [SRC_W-1:0]   winner;
        bit [LEVEL_W-1:0] level;
    } t_arb_outcome;

    // Keeps its own copy of the controller state and predicts each arbitration.
    // It also checks every result against the oldest outcome still owed.
    class irq_scoreboard;
        bit [WORD_W-1:0]      prio_a, prio_b, prio_c;
        bit [NUM_SOURCES-1:0] pend_mask, enab_mask;
        t_arb_outcome         owed[$];
        int                   errors;

        function new();
            prio_a    = '0;
            prio_b    = '0;
            prio_c    = '0;
            pend_mask = '0;
            enab_mask = '1;
            errors    = 0;
        endfunction

        function void write_word(bit [CFG_IDX_W-1:0] idx, bit [WORD_W-1:0] data);
            case (idx)
                CFG_WORD_A: prio_a = data;
                CFG_WORD_B: prio_b = data;
                CFG_WORD_C: prio_c = data;
                default: ;
            endcase
        endfunction

        function bit [LEVEL_W-1:0] level_of(int idx);
            bit [WORD_W-1:0] word;
            case (SRC_TAB[idx].sel)
                LVL_WORD_A: word = prio_a;
                LVL_WORD_B: word = prio_b;
                LVL_WORD_C: word = prio_c;
                default: return SRC_TAB[idx].arg;
            endcase
            return word[4*SRC_TAB[idx].arg[1:0] +: 4];
        endfunction

        // Applies the bit update of an accepted command and queues the arbitration outcome.
        function void note_command(bit [MODE_W-1:0] mode, bit [SRC_W-1:0] src,
                                   bit [LEVEL_W-1:0] imask, bit blk);
            t_arb_outcome         res;
            bit [NUM_SOURCES-1:0] live;
            bit [LEVEL_W-1:0]     lv;
            res = '{take: 1'b0, code: '0, winner: '0, level: '0};
            if (src < NUM_SOURCES) begin
                case (mode)
                    MODE_SET_PEND: pend_mask[src] = 1'b1;
                    MODE_CLR_PEND: pend_mask[src] = 1'b0;
                    MODE_ENABLE:   enab_mask[src] = 1'b1;
                    MODE_DISABLE:  enab_mask[src] = 1'b0;
                    default: ;
                endcase
            end
            if (!blk) begin
                live = pend_mask & enab_mask;
                for (int i = 0; i < NUM_SOURCES; i++) begin
                    lv = level_of(i);
                    // Equal levels let the later, higher index take over.
                    if (live[i] && lv > imask && (!res.take || lv >= res.level)) begin
                        res.take   = 1'b1;
                        res.code   = SRC_TAB[i].code;
                        res.winner = SRC_W'(i);
                        res.level  = lv;
                    end
                end
            end
            owed.push_back(res);
        endfunction

        function void check_result(bit take, bit [CODE_W-1:0] code,
                                   bit [SRC_W-1:0] winner, bit [LEVEL_W-1:0] level);
            t_arb_outcome exp_res;
            if (owed.size() == 0) begin
                $error("result arrived with no command outstanding");
                errors++;
                return;
            end
            exp_res = owed.pop_front();
            if (take != exp_res.take) begin
                $error("take: expected %0d, actual %0d", exp_res.take, take);
                errors++;
            end
            if (code != exp_res.code) begin
                $error("event_code: expected 0x%0h, actual 0x%0h", exp_res.code, code);
                errors++;
            end
            if (winner != exp_res.winner) begin
                $error("winner: expected %0d, actual %0d", exp_res.winner, winner);
                errors++;
            end
            if (level != exp_res.level) begin
                $error("win_level: expected %0d, actual %0d", exp_res.level, level);
                errors++;
            end
        endfunction

        function int outstanding();
            return owed.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [MODE_W-1:0]    i_mode;
    logic [SRC_W-1:0]     i_source;
    logic [LEVEL_W-1:0]   i_sr_imask;
    logic                 i_sr_block;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;
    logic                 o_valid;
    logic                 o_take;
    logic [CODE_W-1:0]    o_event_code;
    logic [SRC_W-1:0]     o_winner;
    logic [LEVEL_W-1:0]   o_win_level;

    irq_scoreboard board = new();
    int            cycle_count = 0;

    priority_interrupt_controller uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_mode       (i_mode),
        .i_source     (i_source),
        .i_sr_imask   (i_sr_imask),
        .i_sr_block   (i_sr_block),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_take       (o_take),
        .o_event_code (o_event_code),
        .o_winner     (o_winner),
        .o_win_level  (o_win_level)
    );

    // 20 ns clock: half a period low, then half a period high.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // This is a watchdog for a hung handshake or for results that never arrive.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // The monitor samples at the rising edge, so it sees the values that the edge acts on.
    // A result here always belongs to an earlier command, registered in the state and then the
    // arbiter stage. The result is therefore checked before the command of this edge is recorded.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                board.check_result(o_take, o_event_code, o_winner, o_win_level);
            end
            if (i_start && !o_busy) begin
                board.note_command(i_mode, i_source, i_sr_imask, i_sr_block);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                board.write_word(i_cfg_index, i_cfg_data);
            end
        end
    end

    // This task presents one command and returns at the edge that accepts the transaction.
    // i_start stays high after it returns. A back-to-back command therefore reuses the strobe.
    task automatic drive_command(input logic [MODE_W-1:0] mode, input logic [SRC_W-1:0] src,
                                 input logic [LEVEL_W-1:0] imask, input logic blk);
        i_start    <= 1'b1;
        i_mode     <= mode;
        i_source   <= src;
        i_sr_imask <= imask;
        i_sr_block <= blk;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // This task holds off new commands until every owed result has arrived.
    // It then leaves a few cycles of slack, so that the block is idle for a register write.
    task automatic drain_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_priorities(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                                  input logic [WORD_W-1:0] c);
        drain_results();
        write_register(CFG_WORD_A, a);
        write_register(CFG_WORD_B, b);
        write_register(CFG_WORD_C, c);
    endtask

    // Random commands raise pending bits more often than any other mode, so that several sources compete.
    // Clears and disables keep the set moving. The mask is biased low, so that many
    // arbitrations produce a winner. A few commands use an unused mode or a source
    // out of range.
    task automatic run_random_phase(input int count, input int gap_odds);
        int                 pick;
        logic [MODE_W-1:0]  mode;
        logic [SRC_W-1:0]   src;
        logic [LEVEL_W-1:0] imask;
        logic               blk;
        for (int n = 0; n < count; n++) begin
            if (gap_odds > 0 && $urandom_range(0, gap_odds - 1) == 0) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)      mode = MODE_SET_PEND;
            else if (pick < 58) mode = MODE_CLR_PEND;
            else if (pick < 76) mode = MODE_ENABLE;
            else if (pick < 86) mode = MODE_DISABLE;
            else if (pick < 94) mode = MODE_EVAL;
            else                mode = MODE_W'($urandom_range(5, 7));
            if ($urandom_range(0, 19) == 0) src = SRC_W'($urandom_range(NUM_SOURCES, 31));
            else                            src = SRC_W'($urandom_range(0, NUM_SOURCES - 1));
            if ($urandom_range(0, 1) == 0) imask = LEVEL_W'($urandom_range(0, 15));
            else                           imask = LEVEL_W'($urandom_range(0, 5));
            blk = ($urandom_range(0, 7) == 0);
            drive_command(mode, src, imask, blk);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_mode      = MODE_EVAL;
        i_source    = '0;
        i_sr_imask  = '0;
        i_sr_block  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_WORD_A;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // These directed commands use the reset priority words. Only the lines at fixed
        // levels can win, since every programmable source sits at level zero.
        drive_command(MODE_EVAL,     5'd0,  4'd0,  1'b0);  // Nothing pending, so no winner.
        drive_command(MODE_SET_PEND, 5'd0,  4'd0,  1'b0);  // Line at level 6 wins.
        drive_command(MODE_SET_PEND, 5'd1,  4'd15, 1'b1);  // Block bit suppresses all.
        drive_command(MODE_EVAL,     5'd0,  4'd5,  1'b0);
        drive_command(MODE_EVAL,     5'd0,  4'd6,  1'b0);  // Mask equal to the level: none.
        drive_command(MODE_SET_PEND, 5'd3,  4'd0,  1'b0);  // Level zero source never wins.
        drive_command(MODE_DISABLE,  5'd0,  4'd0,  1'b0);  // Level 4 line takes over.
        drive_command(MODE_DISABLE,  5'd1,  4'd0,  1'b0);  // Only level zero is left.
        drive_command(MODE_SET_PEND, 5'd31, 4'd0,  1'b0);  // Out of range source changes nothing.
        drive_command(3'd7,          5'd2,  4'd0,  1'b0);  // Unused mode only evaluates.
        drive_command(MODE_ENABLE,   5'd0,  4'd0,  1'b0);
        drive_command(MODE_CLR_PEND, 5'd0,  4'd0,  1'b0);
        drive_command(MODE_ENABLE,   5'd1,  4'd3,  1'b0);

        // Every nibble is now at the top level. The pending programmable sources tie, and
        // source 27 wins because its index is higher.
        set_priorities(16'hFFFF, 16'hFFFF, 16'hFFFF);
        drive_command(MODE_SET_PEND, 5'd27, 4'd14, 1'b0);
        drive_command(MODE_SET_PEND, 5'd26, 4'd0,  1'b0);
        drive_command(MODE_CLR_PEND, 5'd27, 4'd0,  1'b0);
        drive_command(MODE_EVAL,     5'd16, 4'd15, 1'b0);  // No level exceeds mask 15.
        drive_command(MODE_SET_PEND, 5'd16, 4'd14, 1'b1);

        // These phases use random commands, each under its own priority setting.
        // Each change of setting first drains every owed result. Index 3 is
        // written once; the block ignores it.
        set_priorities(16'h0000, 16'h0000, 16'h0000);
        write_register(2'd3, 16'($urandom));
        run_random_phase(PHASE_ITEMS, 4);
        set_priorities(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random_phase(PHASE_ITEMS, 3);
        for (int p = 0; p < 3; p++) begin
            set_priorities(16'($urandom), 16'($urandom), 16'($urandom));
            run_random_phase(PHASE_ITEMS, (p == 1) ? 0 : 5);
        end
        // The last stretch runs with the strobe held high and no idle cycles.
        set_priorities(16'($urandom), 16'($urandom), 16'($urandom));
        run_random_phase(PHASE_ITEMS, 0);

        drain_results();
        if (board.outstanding() != 0) begin
            $error("%0d results never arrived", board.outstanding());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/pic_pkg.sv
rtl/pic_state.sv
rtl/pic_arbiter.sv
rtl/priority_interrupt_controller.sv
dv/tb_priority_interrupt_controller.sv
